[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the engine's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STBE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The condition must never be true.
`define STBE_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[hw/rtl/stbe_pkg.sv]
`timescale 1ns / 1ps
package stbe_pkg;

   // Port count and derived widths.
   localparam int NUM_PORTS = 8;
   localparam int MAX_OUT   = 8;
   localparam int PIDX_W    = $clog2(NUM_PORTS);
   localparam int PCNT_W    = $clog2(NUM_PORTS + 1);
   localparam int NOUT_W    = $clog2(MAX_OUT + 1);

   // Command queue between front and back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Stream and register port widths.
   localparam int TDATA_W    = 184;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_BRIDGE_ID  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PORT_PRIO  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LINK_COST  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ACTIVE     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_HELLO_IVAL = 3'd4;

   typedef enum logic {
      OP_BPDU = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  port;
      logic [63:0] root;
      logic [31:0] cost;
      logic [63:0] bridge;
      logic [15:0] pid;
   } cmd_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   typedef struct packed {
      logic [63:0] root;
      logic [31:0] cost;
      logic [63:0] bridge;
      logic [15:0] pid;
   } vec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_BEST,
      ST_ROOT,
      ST_DESIG,
      ST_SEND,
      ST_REPLY
   } state_type;

   // Priority vectors order field by field; smaller is better.
   function automatic logic vec_less(vec_type a, vec_type b);
      return {a.root, a.cost, a.bridge, a.pid} < {b.root, b.cost, b.bridge, b.pid};
   endfunction

   // Own port identifier: priority byte above index plus one.
   function automatic logic [15:0] own_pid(logic [7:0] prio, logic [7:0] idx);
      return {prio, idx + 8'd1};
   endfunction

endpackage

[hw/rtl/stbe_front.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stbe_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [stbe_pkg::TDATA_W-1:0] req_tdata,  // rx_port, rx_root_id, rx_path_cost,
                                                     // rx_bridge_id, rx_port_id
   input  logic                         req_tuser,  // opcode
   output stbe_pkg::qhead_type          q_head,
   input  logic                         q_pop
);

   stbe_pkg::cmd_type             mem_ff [stbe_pkg::QDEPTH];
   logic [stbe_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [stbe_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [stbe_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   stbe_pkg::cmd_type             cmd;
   logic                          push;

   // Split the transfer into a command.
   always_comb begin
      cmd.op     = stbe_pkg::op_type'(req_tuser);
      cmd.port   = req_tdata[2:0];
      cmd.root   = req_tdata[66:3];
      cmd.cost   = req_tdata[98:67];
      cmd.bridge = req_tdata[162:99];
      cmd.pid    = req_tdata[178:163];
   end

   assign req_tready = cnt_ff < stbe_pkg::QCNT_W'(stbe_pkg::QDEPTH);
   assign push       = req_tvalid && req_tready;

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + stbe_pkg::QCNT_W'(push) - stbe_pkg::QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign q_head.valid = cnt_ff != '0;
   assign q_head.cmd   = mem_ff[rd_ptr_ff];

   `STBE_ASSERT_NEVER(a_q_over, clock, reset, cnt_ff > stbe_pkg::QCNT_W'(stbe_pkg::QDEPTH), "queue overfilled")
   `STBE_ASSERT_IMP(a_q_pop_empty, clock, reset, q_pop, cnt_ff != '0, "pop from empty queue")

endmodule

[hw/rtl/stbe_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stbe_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [stbe_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [stbe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  stbe_pkg::qhead_type              q_head,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [stbe_pkg::TDATA_W-1:0]     rsp_tdata,
   output logic                             rsp_tlast
);

   // Configuration.
   logic [63:0] bridge_ff;
   logic [7:0]  prio_ff;
   logic [15:0] link_ff;
   logic [3:0]  active_ff;
   logic [15:0] ival_ff;

   // Per-port designated vectors.
   logic [63:0] port_root_ff   [stbe_pkg::NUM_PORTS];
   logic [31:0] port_cost_ff   [stbe_pkg::NUM_PORTS];
   logic [63:0] port_bridge_ff [stbe_pkg::NUM_PORTS];
   logic [15:0] port_ident_ff  [stbe_pkg::NUM_PORTS];

   // Bridge state.
   logic [63:0] own_root_ff, own_root_in;
   logic [31:0] own_cost_ff, own_cost_in;
   logic        rpv_ff, rpv_in;
   logic        run_ff, run_in;
   logic [15:0] hcnt_ff, hcnt_in;
   logic        was_root_ff, was_root_in;

   // Sequencer.
   stbe_pkg::state_type          state_ff, state_in;
   stbe_pkg::cmd_type            cmd_ff, cmd_in;
   logic [stbe_pkg::PCNT_W-1:0]  idx_ff, idx_in;
   logic [stbe_pkg::NOUT_W-1:0]  nsent_ff, nsent_in;
   logic                         best_v_ff, best_v_in;
   logic [stbe_pkg::PIDX_W-1:0]  best_idx_ff, best_idx_in;
   stbe_pkg::vec_type            best_vec_ff, best_vec_in;

   // Output register.
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [stbe_pkg::TDATA_W-1:0] rsp_tdata_ff;
   logic                         rsp_tlast_ff;

   logic                         init_en;
   logic [63:0]                  init_bridge;
   logic [7:0]                   init_prio;
   logic [stbe_pkg::PCNT_W-1:0]  na;
   logic [stbe_pkg::NUM_PORTS-1:0] desig;
   logic [stbe_pkg::PIDX_W-1:0]  p_a, idx_a, rd_a, emit_a;
   stbe_pkg::vec_type            rd_vec, rx_vec, offer_vec;
   logic                         p_ok, rx_better, can_send, out_free, out_load, out_last;
   logic                         later_desig, tick_fire, idx_end, send_done, now_root;
   logic [15:0]                  hcnt_inc, ival_eff;
   logic [32:0]                  cost_sum;
   logic                         st_we, dz_we, rf_we;

   // Identity writes restart the protocol with the new values.
   always_comb begin
      init_en     = reset || (csr_we && (csr_addr == stbe_pkg::REG_BRIDGE_ID ||
                                         csr_addr == stbe_pkg::REG_PORT_PRIO));
      init_bridge = reset ? 64'd0 : bridge_ff;
      init_prio   = reset ? 8'd128 : prio_ff;
      if (!reset && csr_we && csr_addr == stbe_pkg::REG_BRIDGE_ID) begin
         init_bridge = csr_wdata;
      end
      if (!reset && csr_we && csr_addr == stbe_pkg::REG_PORT_PRIO) begin
         init_prio = csr_wdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bridge_ff <= '0;
         prio_ff   <= 8'd128;
         link_ff   <= 16'd1;
         active_ff <= 4'd8;
         ival_ff   <= 16'd2;
      end else if (csr_we) begin
         case (csr_addr)
            stbe_pkg::REG_BRIDGE_ID:  bridge_ff <= csr_wdata;
            stbe_pkg::REG_PORT_PRIO:  prio_ff   <= csr_wdata[7:0];
            stbe_pkg::REG_LINK_COST:  link_ff   <= csr_wdata[15:0];
            stbe_pkg::REG_ACTIVE:     active_ff <= csr_wdata[3:0];
            stbe_pkg::REG_HELLO_IVAL: ival_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Effective port count, clamped to one and to the port count.
   always_comb begin
      if (active_ff == 4'd0) begin
         na = stbe_pkg::PCNT_W'(1);
      end else if (5'(active_ff) > 5'(stbe_pkg::NUM_PORTS)) begin
         na = stbe_pkg::PCNT_W'(stbe_pkg::NUM_PORTS);
      end else begin
         na = stbe_pkg::PCNT_W'(active_ff);
      end
   end

   // A port is designated while it holds our own bridge and port id.
   always_comb begin
      for (int j = 0; j < stbe_pkg::NUM_PORTS; j++) begin
         desig[j] = port_bridge_ff[j] == bridge_ff &&
                    port_ident_ff[j] == stbe_pkg::own_pid(prio_ff, 8'(j));
      end
   end

   // Table read port: the received port in ST_CMP, the walk index otherwise.
   always_comb begin
      p_a    = stbe_pkg::PIDX_W'(cmd_ff.port);
      idx_a  = idx_ff[stbe_pkg::PIDX_W-1:0];
      rd_a   = (state_ff == stbe_pkg::ST_CMP) ? p_a : idx_a;
      rd_vec.root   = port_root_ff[rd_a];
      rd_vec.cost   = port_cost_ff[rd_a];
      rd_vec.bridge = port_bridge_ff[rd_a];
      rd_vec.pid    = port_ident_ff[rd_a];
      rx_vec.root   = cmd_ff.root;
      rx_vec.cost   = cmd_ff.cost;
      rx_vec.bridge = cmd_ff.bridge;
      rx_vec.pid    = cmd_ff.pid;
      offer_vec.root   = own_root_ff;
      offer_vec.cost   = own_cost_ff;
      offer_vec.bridge = bridge_ff;
      offer_vec.pid    = stbe_pkg::own_pid(prio_ff, 8'(idx_a));
   end

   // Status terms used by the FSM blocks.
   always_comb begin
      p_ok      = 8'(cmd_ff.port) < 8'(na);
      rx_better = stbe_pkg::vec_less(rx_vec, rd_vec);
      can_send  = own_root_ff == bridge_ff || rpv_ff;
      out_free  = !rsp_tvalid_ff || rsp_tready;
      idx_end   = idx_ff == na;
      send_done = !can_send || idx_end || nsent_ff == stbe_pkg::NOUT_W'(stbe_pkg::MAX_OUT);
      now_root  = own_root_ff == bridge_ff;
      hcnt_inc  = hcnt_ff + 16'd1;
      ival_eff  = (ival_ff == 16'd0) ? 16'd1 : ival_ff;
      tick_fire = run_ff && hcnt_inc >= ival_eff;
      cost_sum  = {1'b0, best_vec_ff.cost} + 33'(link_ff);
      later_desig = 1'b0;
      for (int j = 0; j < stbe_pkg::NUM_PORTS; j++) begin
         if (stbe_pkg::PCNT_W'(j) > idx_ff && stbe_pkg::PCNT_W'(j) < na && desig[j]) begin
            later_desig = 1'b1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stbe_pkg::ST_IDLE: begin
            if (q_head.valid) begin
               if (q_head.cmd.op == stbe_pkg::OP_TICK) begin
                  state_in = tick_fire ? stbe_pkg::ST_SEND : stbe_pkg::ST_IDLE;
               end else begin
                  state_in = stbe_pkg::ST_CMP;
               end
            end
         end
         stbe_pkg::ST_CMP: begin
            if (!p_ok) begin
               state_in = stbe_pkg::ST_IDLE;
            end else if (!rx_better) begin
               state_in = can_send ? stbe_pkg::ST_REPLY : stbe_pkg::ST_IDLE;
            end else begin
               state_in = stbe_pkg::ST_BEST;
            end
         end
         stbe_pkg::ST_BEST:  if (idx_end) state_in = stbe_pkg::ST_ROOT;
         stbe_pkg::ST_ROOT:  state_in = stbe_pkg::ST_DESIG;
         stbe_pkg::ST_DESIG: if (idx_end) state_in = stbe_pkg::ST_SEND;
         stbe_pkg::ST_SEND:  if (send_done) state_in = stbe_pkg::ST_IDLE;
         stbe_pkg::ST_REPLY: if (out_free) state_in = stbe_pkg::ST_IDLE;
         default:            state_in = stbe_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls per state.
   always_comb begin
      q_pop       = 1'b0;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      nsent_in    = nsent_ff;
      best_v_in   = best_v_ff;
      best_idx_in = best_idx_ff;
      best_vec_in = best_vec_ff;
      own_root_in = own_root_ff;
      own_cost_in = own_cost_ff;
      rpv_in      = rpv_ff;
      run_in      = run_ff;
      hcnt_in     = hcnt_ff;
      was_root_in = was_root_ff;
      st_we       = 1'b0;
      dz_we       = 1'b0;
      rf_we       = 1'b0;
      out_load    = 1'b0;
      out_last    = 1'b0;
      emit_a      = idx_a;
      unique case (state_ff)
         stbe_pkg::ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_head.cmd;
               idx_in   = '0;
               nsent_in = '0;
               if (q_head.cmd.op == stbe_pkg::OP_TICK && run_ff) begin
                  hcnt_in = tick_fire ? 16'd0 : hcnt_inc;
               end
            end
         end
         stbe_pkg::ST_CMP: begin
            if (p_ok && rx_better) begin
               st_we       = 1'b1;
               was_root_in = own_root_ff == bridge_ff;
               best_v_in   = 1'b0;
               idx_in      = '0;
            end
         end
         stbe_pkg::ST_BEST: begin
            // Root port search: lowest index wins ties.
            if (!idx_end) begin
               if (!desig[idx_a] && (!best_v_ff || stbe_pkg::vec_less(rd_vec, best_vec_ff))) begin
                  best_v_in   = 1'b1;
                  best_idx_in = idx_a;
                  best_vec_in = rd_vec;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         stbe_pkg::ST_ROOT: begin
            rpv_in = best_v_ff;
            if (best_v_ff) begin
               own_root_in = best_vec_ff.root;
               own_cost_in = cost_sum[32] ? 32'hFFFF_FFFF : cost_sum[31:0];
            end else begin
               own_root_in = bridge_ff;
               own_cost_in = '0;
            end
            idx_in = '0;
         end
         stbe_pkg::ST_DESIG: begin
            if (idx_end) begin
               if (was_root_ff && !now_root) begin
                  run_in = 1'b0;
               end
               if (!was_root_ff && now_root) begin
                  run_in  = 1'b1;
                  hcnt_in = '0;
               end
               idx_in   = '0;
               nsent_in = '0;
            end else begin
               if (desig[idx_a]) begin
                  rf_we = 1'b1;
               end else if (!(best_v_ff && best_idx_ff == idx_a) &&
                            stbe_pkg::vec_less(offer_vec, rd_vec)) begin
                  dz_we = 1'b1;
                  rf_we = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         stbe_pkg::ST_SEND: begin
            if (!send_done) begin
               if (!desig[idx_a]) begin
                  idx_in = idx_ff + 1'b1;
               end else if (out_free) begin
                  out_load = 1'b1;
                  out_last = !later_desig ||
                             nsent_ff == stbe_pkg::NOUT_W'(stbe_pkg::MAX_OUT - 1);
                  nsent_in = nsent_ff + 1'b1;
                  idx_in   = idx_ff + 1'b1;
               end
            end
         end
         stbe_pkg::ST_REPLY: begin
            emit_a = p_a;
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stbe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      nsent_ff    <= nsent_in;
      best_v_ff   <= best_v_in;
      best_idx_ff <= best_idx_in;
      best_vec_ff <= best_vec_in;
      was_root_ff <= was_root_in;
   end

   // Bridge state and the vector table, both restarted on reset and on identity change.
   always_ff @(posedge clock) begin
      if (init_en) begin
         own_root_ff <= init_bridge;
         own_cost_ff <= '0;
         rpv_ff      <= 1'b0;
         run_ff      <= 1'b1;
         hcnt_ff     <= '0;
         for (int j = 0; j < stbe_pkg::NUM_PORTS; j++) begin
            port_root_ff[j]   <= init_bridge;
            port_cost_ff[j]   <= '0;
            port_bridge_ff[j] <= init_bridge;
            port_ident_ff[j]  <= stbe_pkg::own_pid(init_prio, 8'(j));
         end
      end else begin
         own_root_ff <= own_root_in;
         own_cost_ff <= own_cost_in;
         rpv_ff      <= rpv_in;
         run_ff      <= run_in;
         hcnt_ff     <= hcnt_in;
         if (st_we) begin
            port_root_ff[p_a]   <= cmd_ff.root;
            port_cost_ff[p_a]   <= cmd_ff.cost;
            port_bridge_ff[p_a] <= cmd_ff.bridge;
            port_ident_ff[p_a]  <= cmd_ff.pid;
         end
         if (dz_we) begin
            port_bridge_ff[idx_a] <= bridge_ff;
            port_ident_ff[idx_a]  <= offer_vec.pid;
         end
         if (rf_we) begin
            port_root_ff[idx_a] <= own_root_ff;
            port_cost_ff[idx_a] <= own_cost_ff;
         end
      end
   end

   // Output register: a result waits here while the next one is prepared.
   assign rsp_tvalid_in = out_load || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (out_load) begin
         rsp_tdata_ff <= {5'd0, stbe_pkg::own_pid(prio_ff, 8'(emit_a)), bridge_ff,
                          own_cost_ff, own_root_ff, 3'(emit_a)};
         rsp_tlast_ff <= out_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `STBE_ASSERT_NEVER(a_nsent_cap, clock, reset, nsent_ff > stbe_pkg::NOUT_W'(stbe_pkg::MAX_OUT), "too many results for one item")
   `STBE_ASSERT_IMP(a_load_state, clock, reset, out_load, state_ff == stbe_pkg::ST_SEND || state_ff == stbe_pkg::ST_REPLY, "result loaded outside a sending state")
   `STBE_ASSERT_NEXT(a_root_port, clock, reset, state_ff == stbe_pkg::ST_ROOT && !init_en, rpv_ff == $past(best_v_ff), "root port flag not taken from search")

endmodule

[hw/rtl/spanning_tree_bpdu_engine_top.sv]
`timescale 1ns / 1ps
// Spanning tree configuration-BPDU engine.
// req_ carries one item per transfer: a received config BPDU (req_tuser low)
// or a one-time tick (req_tuser high). rsp_ returns BPDUs to send, tlast on
// the final one caused by an item. csr_ writes one of the five configuration
// registers per write; writing the bridge id or port priority restarts
// all protocol state.
// Items enter a two-entry command queue and are executed one at a time by a
// sequencer that walks the port table one port per cycle while the output
// is not stalled. A better BPDU runs a root search, a designation pass and
// a send pass over the active ports; a BPDU that is not better is answered
// on its own port when this bridge may send; a tick sends only when the
// hello timer expires. Reset restores the configuration, bridge state,
// per-port vectors and sequencer and queue control; there is no clearing
// pass. When the receiver stalls, the result waits in the output register
// and the sequencer holds at its next one; the queue takes items until full.
module spanning_tree_bpdu_engine_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [stbe_pkg::TDATA_W-1:0]    req_tdata,  // rx_port, rx_root_id, rx_path_cost,
                                                        // rx_bridge_id, rx_port_id
   input  logic                            req_tuser,  // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [stbe_pkg::TDATA_W-1:0]    rsp_tdata,  // tx_port, tx_root_id, tx_path_cost,
                                                        // tx_bridge_id, tx_port_id
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [stbe_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [stbe_pkg::CSR_DATA_W-1:0] csr_wdata
);

   stbe_pkg::qhead_type q_head;
   logic                q_pop;

   stbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   stbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
